[hw/rtl/cfs_pkg.sv]
`default_nettype none

package cfs_pkg;

  // Byte codes the filter looks for.
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_EQUAL   = 8'h3d;
  localparam logic [7:0] CH_DASH    = 8'h2d;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;

  // The keyword "exec", first byte in the top bits.
  localparam logic [31:0] EXEC_WORD = 32'h65786563;

  // Lookahead: four held bytes plus the incoming one.
  localparam int unsigned WIN_DEPTH = 5;
  localparam int unsigned CNT_W     = 3;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_NAME   = 2'd1,
    MODE_VALUE  = 2'd2,
    MODE_PASS   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       end_of_string;
  } out_t;

  // A byte with its precomputed classes.
  typedef struct packed {
    logic [7:0] ch;
    logic       is_space;
    logic       is_tab;
    logic       is_equal;
    logic       is_dash;
    logic       is_letter;
  } cls_t;

  // One queue entry between the front and the back.
  typedef struct packed {
    cls_t cls;
    logic last;
  } entry_t;

endpackage

`default_nettype wire

[hw/rtl/cfs_front.sv]
`default_nettype none

// Accepts input words, classifies each byte and holds it in a two-entry queue.
module cfs_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_stall,
  input  wire cfs_pkg::in_t    item,
  output logic                 q_valid,
  output cfs_pkg::entry_t      q_data,
  input  wire logic            q_pop
);

  cfs_pkg::entry_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;
  logic            push;
  cfs_pkg::entry_t new_entry;

  always_comb begin
    new_entry.cls.ch        = item.ch;
    new_entry.cls.is_space  = (item.ch == cfs_pkg::CH_SPACE);
    new_entry.cls.is_tab    = (item.ch == cfs_pkg::CH_TAB);
    new_entry.cls.is_equal  = (item.ch == cfs_pkg::CH_EQUAL);
    new_entry.cls.is_dash   = (item.ch == cfs_pkg::CH_DASH);
    new_entry.cls.is_letter =
      ((item.ch >= cfs_pkg::CH_UPPER_A) && (item.ch <= cfs_pkg::CH_UPPER_Z)) ||
      ((item.ch >= cfs_pkg::CH_LOWER_A) && (item.ch <= cfs_pkg::CH_LOWER_Z));
    new_entry.last          = item.last;
  end

  assign item_stall = (fill == 2'd2);
  assign push       = item_valid && !item_stall;
  assign q_valid    = (fill != 2'd0);
  assign q_data     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !q_pop) begin
        fill <= fill + 2'd1;
      end else if (!push && q_pop) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/cfs_back.sv]
`default_nettype none

// Lookahead window and filter mode: one decision per cycle unless stalled,
// results through an output register. During a final string the newest
// kept byte waits in a pending register so that the end mark can land on it.
module cfs_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire cfs_pkg::entry_t  q_data,
  output logic                  q_pop,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output cfs_pkg::out_t         result
);

  cfs_pkg::cls_t                 win       [cfs_pkg::WIN_DEPTH];
  cfs_pkg::cls_t                 win_i     [cfs_pkg::WIN_DEPTH];
  cfs_pkg::cls_t                 win_next  [cfs_pkg::WIN_DEPTH];
  logic [cfs_pkg::CNT_W-1:0]     win_cnt;
  logic [cfs_pkg::CNT_W-1:0]     win_cnt_i;
  logic [cfs_pkg::CNT_W-1:0]     win_cnt_next;
  cfs_pkg::mode_t                mode;
  cfs_pkg::mode_t                mode_i;
  cfs_pkg::mode_t                mode_next;
  logic                          fin;
  logic                          fin_i;
  logic                          fin_next;
  logic                          pend_valid;
  logic                          pend_valid_next;
  logic [7:0]                    pend_ch;
  logic [7:0]                    pend_ch_next;
  cfs_pkg::out_t                 result_next;

  logic       work;
  logic       final_now;
  logic       exec_hit;
  logic       flag_hit;
  logic       emit;
  logic [1:0] shift;
  logic       out_write;
  logic       advance;
  logic       busy_after;

  assign exec_hit = (win_cnt >= 3'd4) &&
    ({win[0].ch, win[1].ch, win[2].ch, win[3].ch} == cfs_pkg::EXEC_WORD) &&
    ((win_cnt == 3'd4) || win[4].is_space || win[4].is_tab);
  assign flag_hit = (win_cnt >= 3'd3) && win[0].is_dash && win[1].is_dash &&
                    win[2].is_letter;

  always_comb begin
    work      = (win_cnt != 3'd0) &&
                !((mode == cfs_pkg::MODE_NORMAL) && (win_cnt < 3'd5) && !fin);
    final_now = fin && (win_cnt == 3'd0);
    mode_i    = mode;
    emit      = 1'b0;
    shift     = 2'd0;

    if (work) begin
      unique case (mode)
        cfs_pkg::MODE_PASS: begin
          emit  = 1'b1;
          shift = 2'd1;
        end
        cfs_pkg::MODE_NAME: begin
          if (win[0].is_equal) begin
            mode_i = cfs_pkg::MODE_VALUE;
          end else if (win[0].is_space) begin
            mode_i = cfs_pkg::MODE_NORMAL;
          end
          shift = 2'd1;
        end
        cfs_pkg::MODE_VALUE: begin
          if (win[0].is_space) begin
            mode_i = cfs_pkg::MODE_NORMAL;
          end
          shift = 2'd1;
        end
        cfs_pkg::MODE_NORMAL: begin
          if (exec_hit) begin
            mode_i = cfs_pkg::MODE_PASS;
          end else if (flag_hit) begin
            mode_i = cfs_pkg::MODE_NAME;
            shift  = 2'd2;
          end else begin
            emit  = 1'b1;
            shift = 2'd1;
          end
        end
      endcase
    end

    win_i[0] = (shift == 2'd2) ? win[2] : ((shift == 2'd1) ? win[1] : win[0]);
    win_i[1] = (shift == 2'd2) ? win[3] : ((shift == 2'd1) ? win[2] : win[1]);
    win_i[2] = (shift == 2'd2) ? win[4] : ((shift == 2'd1) ? win[3] : win[2]);
    win_i[3] = (shift == 2'd1) ? win[4] : win[3];
    win_i[4] = win[4];
    win_cnt_i = win_cnt - {1'b0, shift};
    fin_i     = fin;

    // The closing word returns everything to the idle state.
    if (final_now) begin
      mode_i    = cfs_pkg::MODE_NORMAL;
      win_cnt_i = '0;
      fin_i     = 1'b0;
    end

    // Results during a final string go through the pending register.
    out_write = final_now || (emit && (!fin || pend_valid));
    advance   = !out_write || !result_valid || !result_stall;

    if (final_now) begin
      result_next.out_char      = pend_valid ? pend_ch : 8'd0;
      result_next.has_char      = pend_valid;
      result_next.end_of_string = 1'b1;
    end else if (fin) begin
      result_next.out_char      = pend_ch;
      result_next.has_char      = 1'b1;
      result_next.end_of_string = 1'b0;
    end else begin
      result_next.out_char      = win[0].ch;
      result_next.has_char      = 1'b1;
      result_next.end_of_string = 1'b0;
    end

    pend_valid_next = pend_valid;
    pend_ch_next    = pend_ch;
    if (final_now) begin
      pend_valid_next = 1'b0;
    end else if (emit && fin) begin
      pend_valid_next = 1'b1;
      pend_ch_next    = win[0].ch;
    end

    // A new byte joins once the current one needs no further decision.
    busy_after = ((win_cnt_i != 3'd0) &&
                  !((mode_i == cfs_pkg::MODE_NORMAL) && (win_cnt_i < 3'd5) && !fin_i)) ||
                 (fin_i && (win_cnt_i == 3'd0));
    q_pop = advance && q_valid && !busy_after;

    win_next     = win_i;
    win_cnt_next = win_cnt_i;
    fin_next     = fin_i;
    mode_next    = mode_i;
    if (q_pop) begin
      win_next[win_cnt_i] = q_data.cls;
      win_cnt_next        = win_cnt_i + 3'd1;
      fin_next            = q_data.last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      win     <= win_next;
      pend_ch <= pend_ch_next;
    end
    if (advance && out_write) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_cnt      <= '0;
      mode         <= cfs_pkg::MODE_NORMAL;
      fin          <= 1'b0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (advance) begin
        win_cnt    <= win_cnt_next;
        mode       <= mode_next;
        fin        <= fin_next;
        pend_valid <= pend_valid_next;
      end
      if (advance && out_write) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/command_flag_stripper_unit.sv]
// Command flag stripper: takes a command string one byte per word and
// returns it with long flags removed ("--" and a letter, the name up to and
// including a space, and after an '=' the value up to and including one
// space). Once "exec" is followed by a space, a tab or the end of the
// string, everything from there on passes unchanged. A word with last set
// closes the string; the final result word carries end_of_string, and a
// string that keeps no byte still yields one word with has_char clear. In
// the steady state with no stalls, one byte is taken and one result given
// per cycle. Each decision starts once four bytes of lookahead are held,
// so results trail the input by four words. The window logic makes one
// decision per cycle unless stalled: an "exec" match is a decision with
// no result, each byte skipped from the lookahead after a flag start is
// one decision, and the end of a string flushes the held bytes one per
// cycle and then gives the closing word. A two-word queue and an output
// register let the input keep flowing while a result waits to be taken.

`default_nettype none

module command_flag_stripper_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_stall,
  input  wire cfs_pkg::in_t  item,
  output logic               result_valid,
  input  wire logic          result_stall,
  output cfs_pkg::out_t      result
);

  logic            q_valid;
  logic            q_pop;
  cfs_pkg::entry_t q_data;

  // Front: byte classes computed on entry and held in a short queue.
  cfs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop)
  );

  // Back: the lookahead window, filter mode and result register.
  cfs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

[verif/flag_strip_checker.sv]
// Watches both channels of the flag stripper, predicts the filtered string
// and compares every result word against the oldest expected word.
module flag_strip_checker
  import cfs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  input  logic item_stall,
  input  in_t  item,
  input  logic result_valid,
  input  logic result_stall,
  input  out_t result,
  output int   fail_count,
  output int   pending,
  output int   checked,
  output int   strings_seen,
  output int   flags_seen,
  output int   exec_seen
);

  localparam int MAX_REPORTS = 10;

  // Predictor state: undecided bytes (oldest in entry 0), their count, mode.
  logic [3:0][7:0] held_bytes;
  int              held_count;
  mode_t           cur_mode;

  out_t filtered_q[$];

  function automatic void strip_flags(in_t w);
    logic [4:0][7:0] la;
    out_t            res[5];
    int              n;
    int              k;
    int              i;
    bit              fin;
    bit              stop;
    bit              exec_hit;
    la = '0;
    la[3:0] = held_bytes;
    n = (held_count > 4) ? 4 : held_count;
    la[n] = w.ch;
    n++;
    fin = w.last;
    k = 0;
    stop = 1'b0;
    while (n > 0 && !stop) begin
      if (cur_mode == MODE_PASS) begin
        for (i = 0; i < n; i++) begin
          res[k] = out_t'{out_char: la[i], has_char: 1'b1, end_of_string: 1'b0};
          k++;
        end
        n = 0;
      end else if (cur_mode == MODE_NAME || cur_mode == MODE_VALUE) begin
        // A space ends the skipped flag; an '=' in the name starts its value.
        if (la[0] == CH_SPACE) begin
          cur_mode = MODE_NORMAL;
        end else if (la[0] == CH_EQUAL && cur_mode == MODE_NAME) begin
          cur_mode = MODE_VALUE;
        end
        la = la >> 8;
        n--;
      end else if (n < 5 && !fin) begin
        stop = 1'b1;
      end else begin
        exec_hit = n >= 4 && {la[0], la[1], la[2], la[3]} == EXEC_WORD &&
                   (n == 4 || la[4] == CH_SPACE || la[4] == CH_TAB);
        if (exec_hit) begin
          cur_mode = MODE_PASS;
          exec_seen++;
        end else if (n >= 3 && la[0] == CH_DASH && la[1] == CH_DASH &&
                     ((la[2] >= CH_UPPER_A && la[2] <= CH_UPPER_Z) ||
                      (la[2] >= CH_LOWER_A && la[2] <= CH_LOWER_Z))) begin
          cur_mode = MODE_NAME;
          flags_seen++;
          la = la >> 16;
          n -= 2;
        end else begin
          res[k] = out_t'{out_char: la[0], has_char: 1'b1, end_of_string: 1'b0};
          k++;
          la = la >> 8;
          n--;
        end
      end
    end
    if (fin) begin
      if (k == 0) begin
        res[0] = out_t'{out_char: 8'h00, has_char: 1'b0, end_of_string: 1'b0};
        k = 1;
      end
      res[k-1].end_of_string = 1'b1;
      held_bytes = '0;
      held_count = 0;
      cur_mode = MODE_NORMAL;
      strings_seen++;
    end else begin
      held_bytes = la[3:0];
      held_count = n;
    end
    for (i = 0; i < k; i++) begin
      filtered_q.push_back(res[i]);
    end
  endfunction

  function automatic void report_failure(string what, out_t exp_w, out_t got_w);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected char %02h has %0d end %0d, got char %02h has %0d end %0d",
               $realtime, what, exp_w.out_char, exp_w.has_char, exp_w.end_of_string,
               got_w.out_char, got_w.has_char, got_w.end_of_string);
    end
  endfunction

  always @(posedge clk) begin
    out_t exp_w;
    if (rst) begin
      held_bytes = '0;
      held_count = 0;
      cur_mode = MODE_NORMAL;
      filtered_q.delete();
      fail_count = 0;
      checked = 0;
      strings_seen = 0;
      flags_seen = 0;
      exec_seen = 0;
    end else begin
      if (item_valid && !item_stall) begin
        strip_flags(item);
      end
      if (result_valid && !result_stall) begin
        checked++;
        if (filtered_q.size() == 0) begin
          report_failure("unexpected word", '0, result);
        end else begin
          exp_w = filtered_q.pop_front();
          if (result.out_char != exp_w.out_char || result.has_char != exp_w.has_char ||
              result.end_of_string != exp_w.end_of_string) begin
            report_failure("word mismatch", exp_w, result);
          end
        end
      end
    end
    pending = filtered_q.size();
  end

endmodule

[verif/tb_command_flag_stripper_unit.sv]
// Testbench top for the command flag stripper. It builds a list of command
// strings, sends them one byte per word with bursty timing, stalls the
// result side on a changing pattern, and gives the verdict. All prediction
// and comparison lives in the checker instance beside the block.
module tb_command_flag_stripper_unit;
  import cfs_pkg::*;

  localparam int RANDOM_WORDS = 190;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 80;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  in_t  item;
  logic result_valid;
  logic result_stall;
  out_t result;

  int mismatches;
  int waiting;
  int checked;
  int strings_seen;
  int flags_seen;
  int exec_seen;

  // Shared between the sender and the receiver: the receiver raises
  // hold_off during its long stall so that the sender stops leaving gaps.
  int words_sent;
  bit hold_off;

  in_t        cmd_words[$];
  logic [7:0] text_bytes[$];

  command_flag_stripper_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  flag_strip_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fail_count   (mismatches),
    .pending      (waiting),
    .checked      (checked),
    .strings_seen (strings_seen),
    .flags_seen   (flags_seen),
    .exec_seen    (exec_seen)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The string under construction is collected byte by byte, then turned
  // into words with last set on its final byte.
  function automatic void add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      text_bytes.push_back(s[i]);
    end
  endfunction

  function automatic void add_letters(int count);
    int i;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 1) == 1) begin
        text_bytes.push_back(CH_UPPER_A + 8'($urandom_range(0, 25)));
      end else begin
        text_bytes.push_back(CH_LOWER_A + 8'($urandom_range(0, 25)));
      end
    end
  endfunction

  // Mostly single spaces, sometimes a tab, a double space, nothing at all,
  // or an arbitrary byte, so that both match rules see odd neighbors.
  function automatic void add_separator();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      text_bytes.push_back(CH_SPACE);
    end else if (pick == 6) begin
      text_bytes.push_back(CH_TAB);
    end else if (pick == 7) begin
      text_bytes.push_back(CH_SPACE);
      text_bytes.push_back(CH_SPACE);
    end else if (pick == 9) begin
      text_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void close_string();
    in_t w;
    int  i;
    for (i = 0; i < text_bytes.size(); i++) begin
      w.ch = text_bytes[i];
      w.last = (i == text_bytes.size() - 1);
      cmd_words.push_back(w);
    end
    text_bytes.delete();
  endfunction

  // Watchdog: a hung handshake ends the run here.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side. The stall pattern is picked anew for each phase from none,
  // light random, periodic and heavy random. Once, in the middle of the
  // traffic, the receiver holds off for a long stretch so that the block's
  // internal queue fills and it has to stall its input.
  initial begin
    int  style;
    int  phase_cycles;
    int  tick;
    bit  held;
    logic stall_next;
    result_stall = 1'b0;
    hold_off = 1'b0;
    style = 0;
    phase_cycles = 0;
    tick = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && words_sent >= 90) begin
        held = 1'b1;
        hold_off = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end
      if (phase_cycles == 0) begin
        style = $urandom_range(0, 3);
        phase_cycles = 50;
      end
      phase_cycles--;
      tick++;
      case (style)
        0: stall_next = 1'b0;
        1: stall_next = ($urandom_range(0, 3) == 0);
        2: stall_next = (tick % 3 == 0);
        default: stall_next = ($urandom_range(0, 9) < 7);
      endcase
      result_stall <= stall_next;
    end
  end

  // Stimulus and verdict.
  initial begin
    int directed_words;
    int ntok;
    int t;
    int idx;
    int burst_left;
    int gap;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    words_sent = 0;

    // Directed strings: a one-byte string, the byte extremes including a
    // zero byte, a flag with a value and its trailing space, exec followed
    // by a tab with a flag after it that must pass, a string that keeps no
    // byte at all, and exec right at the end of the string.
    add_text("a");
    close_string();
    text_bytes.push_back(8'hFF);
    text_bytes.push_back(8'h00);
    text_bytes.push_back(8'h01);
    close_string();
    add_text("--x=1 y");
    close_string();
    add_text("exec\t--q");
    close_string();
    add_text("--Z");
    close_string();
    add_text("exec");
    close_string();
    directed_words = cmd_words.size();

    // Random strings: most are token sequences that look like real commands
    // (words, flags with and without values, exec, near misses of both),
    // the rest are short runs of raw bytes.
    while (cmd_words.size() < directed_words + RANDOM_WORDS) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 7)) begin
          case ($urandom_range(0, 5))
            0: text_bytes.push_back(CH_DASH);
            1: text_bytes.push_back(CH_EQUAL);
            2: text_bytes.push_back(CH_SPACE);
            default: text_bytes.push_back(8'($urandom_range(0, 255)));
          endcase
        end
      end else begin
        ntok = $urandom_range(1, 5);
        for (t = 0; t < ntok; t++) begin
          if (t > 0) begin
            add_separator();
          end
          case ($urandom_range(0, 11))
            0, 1: add_letters($urandom_range(1, 5));
            2, 3: add_text("exec");
            4: begin
              add_text("--");
              add_letters($urandom_range(1, 4));
              add_text("=");
              add_letters($urandom_range(0, 4));
            end
            5: begin
              add_text("--");
              add_letters($urandom_range(1, 6));
            end
            6: begin
              add_text("--");
              text_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
            end
            7: text_bytes.push_back(8'($urandom_range(0, 255)));
            8: begin
              add_text("ex");
              add_letters($urandom_range(0, 2));
            end
            9: add_text("=");
            10: begin
              add_text("--");
              text_bytes.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
              add_text("-");
              add_letters($urandom_range(1, 3));
            end
          endcase
        end
        if ($urandom_range(0, 5) == 0) begin
          add_separator();
        end
      end
      close_string();
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Send in bursts of random length. A burst may open with a gap in which
    // valid is low, except during the receiver's long hold, when words keep
    // coming so that the block backs up.
    idx = 0;
    burst_left = 0;
    @(negedge clk);
    while (idx < cmd_words.size()) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0 || hold_off) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          item_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      item_valid <= 1'b1;
      item <= cmd_words[idx];
      @(posedge clk);
      while (item_stall) @(posedge clk);
      idx++;
      burst_left--;
      words_sent++;
      @(negedge clk);
    end
    item_valid <= 1'b0;

    // Drain: wait for every expected word, then keep watching so that any stray
    // word from the block still shows up as a failure.
    while (waiting != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    $display("Covered %0d words in %0d strings; %0d result words checked.",
             words_sent, strings_seen, checked);
    $display("Stripped %0d long flags, %0d exec pass-throughs, one %0d-cycle output hold.",
             flags_seen, exec_seen, HOLD_CYCLES);
    if (mismatches == 0 && waiting == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
